FILE: src/spba_pkg.sv
package spba_pkg;

    // Field widths of the ports.
    localparam int COORD_W = 18;
    localparam int ANGLE_W = 18;
    localparam int PT_W    = 24;
    localparam int PHI_W   = 16;
    localparam int K_W     = 20;
    localparam int LIM_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Inner point source codes.
    localparam logic [1:0] SRC_HIT3 = 2'd0;
    localparam logic [1:0] SRC_HIT2 = 2'd1;
    localparam logic [1:0] SRC_NONE = 2'd2;

    // Vector angle unit.
    localparam int CRD_IN_W     = 26;
    localparam int CRD_W        = 60;
    localparam int CRD_Z_W      = 28;
    localparam int CRD_STEPS    = 23;
    localparam int CRD_NORM_MSB = 56;
    localparam int CRD_LAT      = CRD_STEPS + 4;
    localparam logic signed [CRD_Z_W-1:0] HALF_TURN = 28'sd16777216;

    // Square root unit.
    localparam int ISQ_IN_W  = 50;
    localparam int ISQ_OUT_W = 25;
    localparam int ISQ_REM_W = 28;
    localparam int ISQ_LAT   = ISQ_OUT_W + 1;

    // Quotient bits of the arcsine argument.
    localparam int DIV_STEPS = LIM_W;

    typedef logic signed [CRD_IN_W-1:0] t_crd_in;
    typedef logic signed [PHI_W-1:0]    t_angle16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURV  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_idx;

    // Arctangent of 2^-i in units of pi/2^24.
    function automatic logic signed [CRD_Z_W-1:0] f_atan(input logic [4:0] idx);
        logic signed [CRD_Z_W-1:0] r;
        case (idx)
            5'd0:    r = 28'sd4194304;
            5'd1:    r = 28'sd2476042;
            5'd2:    r = 28'sd1308273;
            5'd3:    r = 28'sd664100;
            5'd4:    r = 28'sd333338;
            5'd5:    r = 28'sd166832;
            5'd6:    r = 28'sd83436;
            5'd7:    r = 28'sd41721;
            5'd8:    r = 28'sd20861;
            5'd9:    r = 28'sd10430;
            5'd10:   r = 28'sd5215;
            5'd11:   r = 28'sd2608;
            5'd12:   r = 28'sd1304;
            5'd13:   r = 28'sd652;
            5'd14:   r = 28'sd326;
            5'd15:   r = 28'sd163;
            5'd16:   r = 28'sd81;
            5'd17:   r = 28'sd41;
            5'd18:   r = 28'sd20;
            5'd19:   r = 28'sd10;
            5'd20:   r = 28'sd5;
            5'd21:   r = 28'sd3;
            5'd22:   r = 28'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Position of the leading one; zero for a zero word.
    function automatic logic [5:0] f_msb(input logic [CRD_IN_W:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i <= CRD_IN_W; i++) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    // Clamp to the signed angle output range.
    function automatic logic signed [ANGLE_W-1:0] f_sat_angle(input logic signed [19:0] v);
        logic signed [19:0] hi;
        logic signed [19:0] lo;
        logic signed [ANGLE_W-1:0] r;
        hi = 20'((1 << (ANGLE_W - 1)) - 1);
        lo = -hi - 20'sd1;
        if (v > hi) begin
            r = ANGLE_W'(hi);
        end else if (v < lo) begin
            r = ANGLE_W'(lo);
        end else begin
            r = ANGLE_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: src/spba_isqrt.sv
module spba_isqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [spba_pkg::ISQ_IN_W-1:0]  i_value,
    output logic [spba_pkg::ISQ_OUT_W-1:0] o_root
);
    import spba_pkg::*;

    typedef struct packed {
        logic [ISQ_REM_W-1:0] rem;
        logic [ISQ_OUT_W-1:0] root;
        logic [ISQ_IN_W-1:0]  v;
    } t_isq;

    t_isq r_st [ISQ_OUT_W+1];
    t_isq n_st [ISQ_OUT_W+1];

    // One root bit per stage: bring down two radicand bits, try root*4+1.
    always_comb begin
        logic [ISQ_REM_W-1:0] rem2;
        logic [ISQ_REM_W-1:0] trial;
        logic                 ge;
        n_st[0] = '{rem: '0, root: '0, v: i_value};
        for (int k = 0; k < ISQ_OUT_W; k++) begin
            rem2  = {r_st[k].rem[ISQ_REM_W-3:0], r_st[k].v[ISQ_IN_W-1 -: 2]};
            trial = {1'b0, r_st[k].root, 2'b01};
            ge    = (rem2 >= trial);
            n_st[k+1].rem  = ge ? (rem2 - trial) : rem2;
            n_st[k+1].root = {r_st[k].root[ISQ_OUT_W-2:0], ge};
            n_st[k+1].v    = {r_st[k].v[ISQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= ISQ_OUT_W; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_root = r_st[ISQ_OUT_W].root;

endmodule

FILE: src/spba_cordic.sv
module spba_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  spba_pkg::t_crd_in  i_x,
    input  spba_pkg::t_crd_in  i_y,
    output spba_pkg::t_angle16 o_angle
);
    import spba_pkg::*;

    typedef struct packed {
        logic signed [CRD_W-1:0]   x;
        logic signed [CRD_W-1:0]   y;
        logic signed [CRD_Z_W-1:0] z;
        logic                      zero;
    } t_iter;

    // First stage: fold the left half-plane onto the right one.
    logic signed [CRD_IN_W:0]   r_c0_x;
    logic signed [CRD_IN_W:0]   r_c0_y;
    logic signed [CRD_Z_W-1:0]  r_c0_z;
    logic signed [CRD_IN_W:0]   n_c0_x;
    logic signed [CRD_IN_W:0]   n_c0_y;
    logic signed [CRD_Z_W-1:0]  n_c0_z;

    always_comb begin
        logic signed [CRD_IN_W:0] xe;
        logic signed [CRD_IN_W:0] ye;
        xe = (CRD_IN_W+1)'(i_x);
        ye = (CRD_IN_W+1)'(i_y);
        if (xe < 0) begin
            n_c0_x = -xe;
            n_c0_y = -ye;
            n_c0_z = (ye >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            n_c0_x = xe;
            n_c0_y = ye;
            n_c0_z = '0;
        end
    end

    // Second stage: find the shift that brings the leading one of the larger component to bit 56.
    logic signed [CRD_IN_W:0]  r_c1_x;
    logic signed [CRD_IN_W:0]  r_c1_y;
    logic signed [CRD_Z_W-1:0] r_c1_z;
    logic [5:0]                r_c1_sh;
    logic                      r_c1_zero;
    logic [5:0]                n_c1_sh;
    logic                      n_c1_zero;

    always_comb begin
        logic [CRD_IN_W:0] ay;
        logic [CRD_IN_W:0] orv;
        ay        = (r_c0_y < 0) ? (CRD_IN_W+1)'(-r_c0_y) : (CRD_IN_W+1)'(r_c0_y);
        orv       = (CRD_IN_W+1)'(r_c0_x) | ay;
        n_c1_zero = (orv == '0);
        n_c1_sh   = 6'(CRD_NORM_MSB) - f_msb(orv);
    end

    // Third stage onward: normalize, then one rotation per stage.
    t_iter r_it [CRD_STEPS+1];
    t_iter n_it [CRD_STEPS+1];

    always_comb begin
        logic signed [CRD_W-1:0] xs;
        logic signed [CRD_W-1:0] ys;
        n_it[0].x    = CRD_W'(r_c1_x) <<< r_c1_sh;
        n_it[0].y    = CRD_W'(r_c1_y) <<< r_c1_sh;
        n_it[0].z    = r_c1_z;
        n_it[0].zero = r_c1_zero;
        for (int i = 0; i < CRD_STEPS; i++) begin
            xs = r_it[i].x >>> i;
            ys = r_it[i].y >>> i;
            n_it[i+1].zero = r_it[i].zero;
            if (r_it[i].y > 0) begin
                n_it[i+1].x = r_it[i].x + ys;
                n_it[i+1].y = r_it[i].y - xs;
                n_it[i+1].z = r_it[i].z + f_atan(5'(i));
            end else begin
                n_it[i+1].x = r_it[i].x - ys;
                n_it[i+1].y = r_it[i].y + xs;
                n_it[i+1].z = r_it[i].z - f_atan(5'(i));
            end
        end
    end

    // Last stage: round to pi/32768 and wrap; a zero vector reads as angle 0.
    t_angle16 r_angle;
    t_angle16 n_angle;

    always_comb begin
        logic signed [CRD_Z_W-1:0] zr;
        zr      = (r_it[CRD_STEPS].z + CRD_Z_W'(256)) >>> 9;
        n_angle = r_it[CRD_STEPS].zero ? '0 : t_angle16'(zr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0_x    <= n_c0_x;
            r_c0_y    <= n_c0_y;
            r_c0_z    <= n_c0_z;
            r_c1_x    <= r_c0_x;
            r_c1_y    <= r_c0_y;
            r_c1_z    <= r_c0_z;
            r_c1_sh   <= n_c1_sh;
            r_c1_zero <= n_c1_zero;
            for (int i = 0; i <= CRD_STEPS; i++) begin
                r_it[i] <= n_it[i];
            end
            r_angle   <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

FILE: src/segment_pair_beta_angles.sv
// Beta angles of one inner/outer segment pairing, fully pipelined: one item
// enters per clock while the output is not held. The pipeline chains the
// outer-segment length square root (26 stages), the 16-bit
// arcsine-argument divider (17 stages), the arcsine cosine square root
// (26 stages) and the 27-stage vector-angle unit, of which four copies run
// side by side, plus a few setup and finishing stages. The whole pipeline
// holds while a finished item waits at the output and the far side is not
// ready, so the input is ready exactly when the output stage can move.
// Configuration writes always complete at once and should be made only while
// no item is in flight.
module segment_pair_beta_angles (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_inner_hit3_x,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_inner_hit3_y,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_inner_hit2_x,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_inner_hit2_y,
    input  logic [1:0]                           i_inner_source,
    input  logic signed [spba_pkg::PT_W-1:0]     i_track_pt,
    input  logic signed [spba_pkg::PHI_W-1:0]    i_track_phi,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_outer_lo_x,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_outer_lo_y,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_outer_up_x,
    input  logic signed [spba_pkg::COORD_W-1:0]  i_outer_up_y,
    input  logic                                 i_outer_present,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_result_valid,
    output logic signed [spba_pkg::ANGLE_W-1:0]  o_beta_in,
    output logic signed [spba_pkg::ANGLE_W-1:0]  o_beta_out,
    output logic signed [spba_pkg::ANGLE_W-1:0]  o_beta_diff,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spba_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [spba_pkg::K_W-1:0]             i_cfg_data
);
    import spba_pkg::*;

    // Register positions along the pipeline, counted from the input register.
    localparam int T_S2  = 2;
    localparam int T_R1  = T_S2 + ISQ_LAT;
    localparam int T_D0  = T_R1 + 2;
    localparam int T_SQ  = T_D0 + DIV_STEPS + 2;
    localparam int T_R2  = T_SQ + ISQ_LAT;
    localparam int T_OUT = T_R2 + CRD_LAT + 2;

    typedef struct packed {
        logic                       ok;
        logic signed [COORD_W:0]    ia_x;
        logic signed [COORD_W:0]    ia_y;
        logic signed [COORD_W:0]    up_rx;
        logic signed [COORD_W:0]    up_ry;
        logic signed [COORD_W:0]    seg_rx;
        logic signed [COORD_W:0]    seg_ry;
        logic signed [PHI_W-1:0]    dir_p;
        logic [PT_W-1:0]            p;
    } t_sb;

    typedef struct packed {
        logic [28:0]      rem;
        logic [LIM_W-1:0] q;
        logic [PT_W-1:0]  p;
        logic             sat;
    } t_div;

    typedef struct packed {
        logic                    ok;
        logic signed [PHI_W-1:0] dir_p;
    } t_fd;

    logic en;

    // Configuration registers.
    logic [K_W-1:0]   r_k;
    logic [LIM_W-1:0] r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= K_W'(95690);
            r_lim <= LIM_W'(62259);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CURV:  r_k   <= i_cfg_data;
                CFG_LIMIT: r_lim <= i_cfg_data[LIM_W-1:0];
                default:   ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Valid bits travel with the items; everything moves when the output can.
    logic [T_OUT-1:0] r_vld;

    assign en          = !r_vld[T_OUT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[T_OUT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T_OUT-2:0], i_in_valid};
        end
    end

    // Input stage: choose the inner point and form the reversed vectors.
    t_sb              n_sb0;
    logic [COORD_W-1:0] n_ux;
    logic [COORD_W-1:0] n_uy;

    always_comb begin
        logic signed [COORD_W:0] ix;
        logic signed [COORD_W:0] iy;
        logic signed [COORD_W:0] upx;
        logic signed [COORD_W:0] upy;
        ix  = (i_inner_source == SRC_HIT3) ? (COORD_W+1)'(i_inner_hit3_x)
                                           : (COORD_W+1)'(i_inner_hit2_x);
        iy  = (i_inner_source == SRC_HIT3) ? (COORD_W+1)'(i_inner_hit3_y)
                                           : (COORD_W+1)'(i_inner_hit2_y);
        upx = (COORD_W+1)'(i_outer_up_x);
        upy = (COORD_W+1)'(i_outer_up_y);
        n_sb0.ok     = (i_inner_source < SRC_NONE) && i_outer_present;
        n_sb0.ia_x   = ix - upx;
        n_sb0.ia_y   = iy - upy;
        n_sb0.up_rx  = -upx;
        n_sb0.up_ry  = -upy;
        n_sb0.seg_rx = (COORD_W+1)'(i_outer_lo_x) - upx;
        n_sb0.seg_ry = (COORD_W+1)'(i_outer_lo_y) - upy;
        // Positive pt points away from phi, negative along it, zero at angle 0.
        if (i_track_pt > 0) begin
            n_sb0.dir_p = {~i_track_phi[PHI_W-1], i_track_phi[PHI_W-2:0]};
        end else if (i_track_pt < 0) begin
            n_sb0.dir_p = i_track_phi;
        end else begin
            n_sb0.dir_p = '0;
        end
        n_sb0.p = (i_track_pt < 0) ? PT_W'(-i_track_pt) : PT_W'(i_track_pt);
        n_ux    = (n_sb0.seg_rx < 0) ? COORD_W'(-n_sb0.seg_rx) : COORD_W'(n_sb0.seg_rx);
        n_uy    = (n_sb0.seg_ry < 0) ? COORD_W'(-n_sb0.seg_ry) : COORD_W'(n_sb0.seg_ry);
    end

    // Sideband line from the input stage to the angle units.
    t_sb r_sb [T_R2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb0;
            for (int j = 1; j < T_R2; j++) begin
                r_sb[j] <= r_sb[j-1];
            end
        end
    end

    // Squares of the outer segment components.
    logic [COORD_W-1:0]     r_ux;
    logic [COORD_W-1:0]     r_uy;
    logic [2*COORD_W-1:0]   r_sq1;
    logic [2*COORD_W-1:0]   r_sq2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux  <= n_ux;
            r_uy  <= n_uy;
            r_sq1 <= r_ux * r_ux;
            r_sq2 <= r_uy * r_uy;
        end
    end

    // Outer segment length.
    logic [ISQ_OUT_W-1:0] dr_root;

    spba_isqrt u_isqrt_dr (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (ISQ_IN_W'(r_sq1) + ISQ_IN_W'(r_sq2)),
        .o_root  (dr_root)
    );

    // Numerator dr * k / 1024.
    logic [28:0]     r_m_num;
    logic [PT_W-1:0] r_m_p;

    always_ff @(posedge i_clk) begin
        logic [38:0] prod;
        if (en) begin
            prod    = 39'(dr_root[18:0]) * 39'(r_k);
            r_m_num <= prod[38:10];
            r_m_p   <= r_sb[T_R1-1].p;
        end
    end

    // Restoring divider for a 16-bit quotient, with a saturation flag up front.
    t_div r_dv [DIV_STEPS+1];
    t_div n_dv [DIV_STEPS+1];

    always_comb begin
        logic [39:0] dsh;
        logic        ge;
        n_dv[0].rem = r_m_num;
        n_dv[0].q   = '0;
        n_dv[0].p   = r_m_p;
        n_dv[0].sat = (40'(r_m_num) >= {r_m_p, 16'b0});
        for (int j = 0; j < DIV_STEPS; j++) begin
            dsh = 40'(r_dv[j].p) << (DIV_STEPS - 1 - j);
            ge  = (40'(r_dv[j].rem) >= dsh);
            n_dv[j+1].p   = r_dv[j].p;
            n_dv[j+1].sat = r_dv[j].sat;
            n_dv[j+1].rem = ge ? (r_dv[j].rem - dsh[28:0]) : r_dv[j].rem;
            n_dv[j+1].q   = r_dv[j].q;
            n_dv[j+1].q[DIV_STEPS-1-j] = ge;
        end
    end

    // Clamped arcsine argument and its square.
    logic [LIM_W-1:0]   r_a;
    logic [LIM_W-1:0]   r_sq_a;
    logic [2*LIM_W-1:0] r_sq_a2;
    logic [LIM_W-1:0]   r_adly [ISQ_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_dv[j] <= n_dv[j];
            end
            if (r_dv[DIV_STEPS].sat || r_dv[DIV_STEPS].q >= r_lim) begin
                r_a <= r_lim;
            end else begin
                r_a <= r_dv[DIV_STEPS].q;
            end
            r_sq_a    <= r_a;
            r_sq_a2   <= r_a * r_a;
            r_adly[0] <= r_sq_a;
            for (int j = 1; j < ISQ_LAT; j++) begin
                r_adly[j] <= r_adly[j-1];
            end
        end
    end

    // Cosine leg of the arcsine triangle.
    logic [ISQ_OUT_W-1:0] xa_root;

    spba_isqrt u_isqrt_cos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value ((ISQ_IN_W'(1) << 48) - ISQ_IN_W'({r_sq_a2, 16'b0})),
        .o_root  (xa_root)
    );

    // Four vector angles side by side.
    t_angle16 ang_axis;
    t_angle16 ang_up;
    t_angle16 ang_seg;
    t_angle16 ang_corr;

    spba_cordic u_crd_axis (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (t_crd_in'(r_sb[T_R2-1].ia_x)),
        .i_y     (t_crd_in'(r_sb[T_R2-1].ia_y)),
        .o_angle (ang_axis)
    );

    spba_cordic u_crd_up (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (t_crd_in'(r_sb[T_R2-1].up_rx)),
        .i_y     (t_crd_in'(r_sb[T_R2-1].up_ry)),
        .o_angle (ang_up)
    );

    spba_cordic u_crd_seg (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (t_crd_in'(r_sb[T_R2-1].seg_rx)),
        .i_y     (t_crd_in'(r_sb[T_R2-1].seg_ry)),
        .o_angle (ang_seg)
    );

    spba_cordic u_crd_corr (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     ($signed({1'b0, xa_root})),
        .i_y     ($signed({2'b00, r_adly[ISQ_LAT-1], 8'b0})),
        .o_angle (ang_corr)
    );

    // Track direction and status ride along with the angle units.
    t_fd r_fd [CRD_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fd[0] <= '{ok: r_sb[T_R2-1].ok, dir_p: r_sb[T_R2-1].dir_p};
            for (int j = 1; j < CRD_LAT; j++) begin
                r_fd[j] <= r_fd[j-1];
            end
        end
    end

    // Turns between directions, each wrapped to a half turn.
    logic               r_f_ok;
    logic signed [19:0] r_f_bin;
    logic signed [19:0] r_f_b0;
    logic signed [19:0] r_f_d0;
    logic signed [19:0] r_f_corr;

    always_ff @(posedge i_clk) begin
        t_angle16           w_in;
        t_angle16           w_seg;
        t_angle16           w_axis;
        logic signed [19:0] bin;
        logic signed [19:0] b0;
        if (en) begin
            w_in     = ang_axis - r_fd[CRD_LAT-1].dir_p;
            w_seg    = ang_seg - ang_up;
            w_axis   = ang_axis - ang_up;
            bin      = -20'(w_in);
            b0       = 20'(w_axis) - 20'(w_seg);
            r_f_ok   <= r_fd[CRD_LAT-1].ok;
            r_f_bin  <= bin;
            r_f_b0   <= b0;
            r_f_d0   <= bin - b0;
            r_f_corr <= (ang_corr < 0) ? '0 : 20'(ang_corr);
        end
    end

    // Output register: the correction pushes betaOut away from zero.
    logic                      r_o_res;
    logic signed [ANGLE_W-1:0] r_o_bin;
    logic signed [ANGLE_W-1:0] r_o_bout;
    logic signed [ANGLE_W-1:0] r_o_diff;

    always_ff @(posedge i_clk) begin
        logic signed [19:0] bout;
        logic signed [19:0] diff;
        if (en) begin
            if (r_f_b0 >= 0) begin
                bout = r_f_b0 + r_f_corr;
                diff = r_f_d0 - r_f_corr;
            end else begin
                bout = r_f_b0 - r_f_corr;
                diff = r_f_d0 + r_f_corr;
            end
            r_o_res  <= r_f_ok;
            r_o_bin  <= r_f_ok ? f_sat_angle(r_f_bin) : '0;
            r_o_bout <= r_f_ok ? f_sat_angle(bout) : '0;
            r_o_diff <= r_f_ok ? f_sat_angle(diff) : '0;
        end
    end

    assign o_result_valid = r_o_res;
    assign o_beta_in      = r_o_bin;
    assign o_beta_out     = r_o_bout;
    assign o_beta_diff    = r_o_diff;

endmodule

FILE: dv/tb_segment_pair_beta_angles.sv
`timescale 1ns / 100ps

module tb_segment_pair_beta_angles;
    import spba_pkg::*;

    // One segment pairing as it enters the block.
    typedef struct {
        logic signed [COORD_W-1:0] h3x, h3y, h2x, h2y;
        logic [1:0]                src;
        logic signed [PT_W-1:0]    pt;
        logic signed [PHI_W-1:0]   phi;
        logic signed [COORD_W-1:0] lox, loy, upx, upy;
        logic                      present;
    } t_seg_pair;

    // Beta angles of one pairing.
    typedef struct {
        logic                      ok;
        logic signed [ANGLE_W-1:0] b_in, b_out, b_diff;
    } t_beta_set;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [COORD_W-1:0] i_inner_hit3_x, i_inner_hit3_y, i_inner_hit2_x, i_inner_hit2_y;
    logic [1:0] i_inner_source;
    logic signed [PT_W-1:0] i_track_pt;
    logic signed [PHI_W-1:0] i_track_phi;
    logic signed [COORD_W-1:0] i_outer_lo_x, i_outer_lo_y, i_outer_up_x, i_outer_up_y;
    logic i_outer_present;
    logic o_out_valid;
    logic i_out_ready;
    logic o_result_valid;
    logic signed [ANGLE_W-1:0] o_beta_in, o_beta_out, o_beta_diff;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [K_W-1:0] i_cfg_data;

    int  mismatches = 0;
    bit  quiet_tail = 0;
    bit  stim_done = 0;

    segment_pair_beta_angles u_dut (.*);

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Predicts the beta angles and holds them until the block returns them.
    class beta_scoreboard;
        longint unsigned curv_k = 95690;
        longint unsigned sin_lim = 62259;
        t_beta_set pending_angles[$];
        longint atan_steps[CRD_STEPS] = '{
            4194304, 2476042, 1308273, 664100, 333338, 166832, 83436, 41721,
            20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

        function longint wrap_half(input longint v);
            logic signed [15:0] w;
            w = v[15:0];
            return w;
        endfunction

        function longint unsigned root_floor(input longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Vector angle in units of pi/2^24; a zero vector reads as 0.
        function longint vec_angle(input longint x, input longint y);
            longint z, xs, ys;
            longint unsigned ax, ay, mag;
            z = 0;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            mag = (ax > ay) ? ax : ay;
            if (mag == 0) return 0;
            while (mag < (64'd1 << 56)) begin
                x = x * 2;
                y = y * 2;
                mag <<= 1;
            end
            if (x < 0) begin
                z = (y >= 0) ? 64'sd16777216 : -64'sd16777216;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CRD_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys;
                    y -= xs;
                    z += atan_steps[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= atan_steps[i];
                end
            end
            return z;
        endfunction

        function longint coarse(input longint z);
            return (z + 256) >>> 9;
        endfunction

        function longint back_dir(input longint x, input longint y);
            return wrap_half(coarse(vec_angle(-x, -y)));
        endfunction

        function logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
            longint hi;
            hi = (64'sd1 <<< (ANGLE_W - 1)) - 1;
            if (v > hi) v = hi;
            if (v < -hi - 1) v = -hi - 1;
            return v[ANGLE_W-1:0];
        endfunction

        function t_beta_set predict_angles(input t_seg_pair p);
            t_beta_set r;
            longint ix, iy, ax, ay, sx, sy, dir_p, dir_axis, dir_up, dir_seg;
            longint b_in, b_out, corr;
            longint unsigned ux, uy, s, dr, pm, q, a, ya, xa;
            r = '{ok: 1'b0, b_in: '0, b_out: '0, b_diff: '0};
            if (p.src >= SRC_NONE || !p.present) return r;
            ix = (p.src == SRC_HIT3) ? p.h3x : p.h2x;
            iy = (p.src == SRC_HIT3) ? p.h3y : p.h2y;
            ax = p.upx - ix;
            ay = p.upy - iy;
            sx = p.upx - p.lox;
            sy = p.upy - p.loy;
            if (p.pt > 0) dir_p = wrap_half(p.phi + 32768);
            else if (p.pt < 0) dir_p = p.phi;
            else dir_p = 0;
            dir_axis = back_dir(ax, ay);
            b_in = -wrap_half(dir_axis - dir_p);
            dir_up = back_dir(p.upx, p.upy);
            dir_seg = back_dir(sx, sy);
            b_out = -wrap_half(dir_seg - dir_up) + wrap_half(dir_axis - dir_up);
            // Curvature correction from the outer segment length.
            ux = (sx < 0) ? -sx : sx;
            uy = (sy < 0) ? -sy : sy;
            s = ux * ux + uy * uy;
            if (s < ux * ux) s = 64'hFFFF_FFFF_FFFF_FFFF;
            dr = root_floor(s);
            pm = (p.pt < 0) ? -longint'(p.pt) : longint'(p.pt);
            if (pm == 0) begin
                a = sin_lim;
            end else begin
                q = (dr * curv_k) / (pm * 1024);
                a = (q < sin_lim) ? q : sin_lim;
            end
            ya = a * 256;
            xa = root_floor((64'd1 << 48) - ya * ya);
            corr = coarse(vec_angle(xa, ya));
            if (corr < 0) corr = 0;
            if (b_out >= 0) b_out += corr;
            else b_out -= corr;
            r.ok = 1'b1;
            r.b_in = clamp_angle(b_in);
            r.b_out = clamp_angle(b_out);
            r.b_diff = clamp_angle(b_in - b_out);
            return r;
        endfunction

        function void note_pair(input t_seg_pair p);
            pending_angles.push_back(predict_angles(p));
        endfunction

        task check_angles(input t_beta_set got);
            t_beta_set exp_set;
            if (pending_angles.size() == 0) begin
                report_mismatch("result with nothing outstanding");
                return;
            end
            exp_set = pending_angles.pop_front();
            if (got.ok !== exp_set.ok)
                report_mismatch($sformatf("result_valid %b, want %b", got.ok, exp_set.ok));
            if (got.b_in !== exp_set.b_in)
                report_mismatch($sformatf("beta_in %0d, want %0d", got.b_in, exp_set.b_in));
            if (got.b_out !== exp_set.b_out)
                report_mismatch($sformatf("beta_out %0d, want %0d", got.b_out, exp_set.b_out));
            if (got.b_diff !== exp_set.b_diff)
                report_mismatch($sformatf("beta_diff %0d, want %0d", got.b_diff,
                                          exp_set.b_diff));
        endtask
    endclass

    beta_scoreboard angle_board = new();

    // Clock.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Offers one pairing, after an optional gap, and holds it until it is taken.
    task automatic send_pair(input t_seg_pair p);
        int gap;
        gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_inner_hit3_x  <= p.h3x;
        i_inner_hit3_y  <= p.h3y;
        i_inner_hit2_x  <= p.h2x;
        i_inner_hit2_y  <= p.h2y;
        i_inner_source  <= p.src;
        i_track_pt      <= p.pt;
        i_track_phi     <= p.phi;
        i_outer_lo_x    <= p.lox;
        i_outer_lo_y    <= p.loy;
        i_outer_up_x    <= p.upx;
        i_outer_up_y    <= p.upy;
        i_outer_present <= p.present;
        do @(posedge i_clk); while (!o_in_ready);
        angle_board.note_pair(p);
    endtask

    // Writes one register once the pipeline has drained.
    task automatic write_reg(input t_cfg_idx idx, input logic [K_W-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (angle_board.pending_angles.size() != 0) @(posedge i_clk);
        repeat (110) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CURV) angle_board.curv_k = val;
        else angle_board.sin_lim = val[LIM_W-1:0];
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return COORD_W'($urandom_range(0, 255) - 128);
            1:       return COORD_W'($urandom_range(0, 8191) - 4096);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // A random pairing: mostly complete ones, some with missing hits.
    function automatic t_seg_pair rand_pair();
        t_seg_pair p;
        p.h3x = rand_coord();
        p.h3y = rand_coord();
        p.h2x = rand_coord();
        p.h2y = rand_coord();
        p.src = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(SRC_NONE, SRC_NONE + 1))
                                            : 2'($urandom_range(SRC_HIT3, SRC_HIT2));
        case ($urandom_range(0, 4))
            0:       p.pt = PT_W'($urandom_range(0, 2047) - 1024);
            1:       p.pt = PT_W'($urandom_range(0, 40) - 20);
            2:       p.pt = '0;
            default: p.pt = PT_W'($urandom());
        endcase
        if ($urandom_range(0, 9) == 0) p.pt = '0;
        p.phi = PHI_W'($urandom());
        p.lox = rand_coord();
        p.loy = rand_coord();
        p.upx = rand_coord();
        p.upy = rand_coord();
        if ($urandom_range(0, 7) == 0) begin
            p.lox = p.upx;
            p.loy = p.upy;
        end
        p.present = ($urandom_range(0, 9) != 0);
        return p;
    endfunction

    function automatic t_seg_pair make_pair(input longint ix, input longint iy,
                                            input longint lx, input longint ly,
                                            input longint ux, input longint uy,
                                            input longint pt, input longint phi,
                                            input logic [1:0] src, input bit present);
        t_seg_pair p;
        p.h3x = COORD_W'(ix);
        p.h3y = COORD_W'(iy);
        p.h2x = COORD_W'(-ix);
        p.h2y = COORD_W'(iy + 7);
        p.src = src;
        p.pt = PT_W'(pt);
        p.phi = PHI_W'(phi);
        p.lox = COORD_W'(lx);
        p.loy = COORD_W'(ly);
        p.upx = COORD_W'(ux);
        p.upy = COORD_W'(uy);
        p.present = present;
        return p;
    endfunction

    // Edge cases: missing hits, zero pt, zero-length vectors, half turns, extremes.
    task automatic send_edge_cases();
        longint mx, mn;
        mx = 131071;
        mn = -131072;
        send_pair(make_pair(100, 200, 300, 400, 500, 600, 1000, 123, SRC_HIT3, 1));
        send_pair(make_pair(100, 200, 300, 400, 500, 600, -1000, 123, SRC_HIT2, 1));
        send_pair(make_pair(100, 200, 300, 400, 500, 600, 1000, 123, SRC_NONE, 1));
        send_pair(make_pair(100, 200, 300, 400, 500, 600, 1000, 123, SRC_NONE + 2'd1, 1));
        send_pair(make_pair(100, 200, 300, 400, 500, 600, 1000, 123, SRC_HIT3, 0));
        send_pair(make_pair(100, 200, 300, 400, 500, 600, 0, 999, SRC_HIT3, 1));
        send_pair(make_pair(500, 600, 300, 400, 500, 600, 77, 0, SRC_HIT3, 1));
        send_pair(make_pair(100, 200, 0, 0, 0, 0, 77, 0, SRC_HIT3, 1));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, SRC_HIT3, 1));
        send_pair(make_pair(-100, 0, 50, 0, 100, 0, -1, 0, SRC_HIT3, 1));
        send_pair(make_pair(100, 0, 200, 0, -100, 0, 1, -32768, SRC_HIT3, 1));
        send_pair(make_pair(0, -100, 0, -50, 0, 100, 1, 32767, SRC_HIT2, 1));
        send_pair(make_pair(mx, mx, mn, mn, mx, mx, 8388607, 32767, SRC_HIT3, 1));
        send_pair(make_pair(mn, mn, mx, mx, mn, mn, -8388608, -32768, SRC_HIT3, 1));
        send_pair(make_pair(mn, mx, mx, mn, mn, mx, 1, 16384, SRC_HIT2, 1));
        send_pair(make_pair(mx, mn, mn, mx, mx, mn, -1, -16384, SRC_HIT2, 1));
        send_pair(make_pair(mn, mn, mx, mx, mx, mn, 3, 1, SRC_HIT3, 1));
        send_pair(make_pair(10, 10, 11, 10, 12, 10, 1, 0, SRC_HIT3, 1));
        send_pair(make_pair(-7, 3, 1000, -2000, -3000, 4000, 2560, -5000, SRC_HIT3, 1));
    endtask

    // Stimulus: directed pairs, then random phases under several settings.
    initial begin
        logic [K_W-1:0] k_set[6];
        logic [K_W-1:0] lim_set[6];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CURV;
        i_cfg_data = '0;
        i_inner_hit3_x = '0;
        i_inner_hit3_y = '0;
        i_inner_hit2_x = '0;
        i_inner_hit2_y = '0;
        i_inner_source = '0;
        i_track_pt = '0;
        i_track_phi = '0;
        i_outer_lo_x = '0;
        i_outer_lo_y = '0;
        i_outer_up_x = '0;
        i_outer_up_y = '0;
        i_outer_present = 1'b0;
        k_set = '{95690, 0, 20'hFFFFF, 20'hFFFFF, 0, 0};
        lim_set = '{62259, 0, 16'hFFFF, 0, 16'hFFFF, 62259};
        k_set[4] = K_W'($urandom());
        k_set[5] = K_W'($urandom_range(1000, 300000));
        lim_set[4] = K_W'($urandom_range(0, 65535));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_edge_cases();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_CURV, k_set[ph]);
            write_reg(CFG_LIMIT, lim_set[ph]);
            @(posedge i_clk);
            if (ph == 5) quiet_tail = 1;
            if (ph == 2) send_edge_cases();
            for (int n = 0; n < 280; n++) send_pair(rand_pair());
        end
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    // Result side: random stall bursts, none at the tail; checks each result.
    initial begin
        int stall;
        t_beta_set got;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.ok = o_result_valid;
                got.b_in = o_beta_in;
                got.b_out = o_beta_out;
                got.b_diff = o_beta_diff;
                angle_board.check_angles(got);
            end
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (angle_board.pending_angles.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[segment_pair_beta_angles] OK");
        end else begin
            $display("[segment_pair_beta_angles] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("[segment_pair_beta_angles] ERROR");
        $finish;
    end

endmodule
